// ===== sv/cfvg_pkg.sv =====
// shared types, constants and tables of the circle fan vertex generator
`default_nettype none
package cfvg_pkg;

	localparam int IDX_W        = 11;
	localparam int COORD_W      = 17;
	localparam int RAD_W        = 16;
	localparam int PTS_W        = 11;
	localparam int PHASE_BITS   = 16;
	localparam int MAX_POINTS   = 1024;
	localparam int CORDIC_STEPS = 24;
	localparam int XW           = 35;
	localparam int ZW           = 32;
	localparam int PROD_W       = 46;
	localparam int GAIN_W       = 30;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;

	localparam logic [GAIN_W-1:0]     CORDIC_GAIN = 30'd652032874;
	localparam logic [RAD_W-1:0]      RADIUS_RST  = 16'd1600;
	localparam logic [PTS_W-1:0]      POINTS_RST  = 11'd50;
	localparam logic [PTS_W-1:0]      POINTS_MIN  = 11'd3;
	localparam logic [PTS_W-1:0]      POINTS_MAX  = PTS_W'(MAX_POINTS);
	localparam logic [CFG_IDX_W-1:0]  REG_RADIUS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0]  REG_POINTS  = 1'b1;
	localparam logic signed [COORD_W-1:0] COORD_MAX = 17'sd65535;
	localparam logic signed [COORD_W-1:0] COORD_MIN = -17'sd65535;

	typedef enum logic [1:0] {
		VK_CENTRE,
		VK_RIM,
		VK_LAST,
		VK_ERROR
	} vkind_t;

	typedef struct packed {
		logic   vld;
		vkind_t kind;
	} tag_t;

	// cordic angle table, units of 2^-32 turn
	function automatic logic signed [ZW-1:0] atan_turn(input logic [4:0] i);
		logic signed [ZW-1:0] t;
		unique case (i)
			5'd0:    t = 32'sd536870912;
			5'd1:    t = 32'sd316933406;
			5'd2:    t = 32'sd167458907;
			5'd3:    t = 32'sd85004756;
			5'd4:    t = 32'sd42667331;
			5'd5:    t = 32'sd21354465;
			5'd6:    t = 32'sd10680862;
			5'd7:    t = 32'sd5340245;
			5'd8:    t = 32'sd2670163;
			5'd9:    t = 32'sd1335087;
			5'd10:   t = 32'sd667544;
			5'd11:   t = 32'sd333772;
			5'd12:   t = 32'sd166886;
			5'd13:   t = 32'sd83443;
			5'd14:   t = 32'sd41722;
			5'd15:   t = 32'sd20861;
			5'd16:   t = 32'sd10430;
			5'd17:   t = 32'sd5215;
			5'd18:   t = 32'sd2608;
			5'd19:   t = 32'sd1304;
			5'd20:   t = 32'sd652;
			5'd21:   t = 32'sd326;
			5'd22:   t = 32'sd163;
			5'd23:   t = 32'sd81;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

// ===== sv/cfvg_if.sv =====
// word channels of the vertex generator
`default_nettype none
interface cfvg_in_if;
	logic                        valid;
	logic                        ready;
	logic [cfvg_pkg::IDX_W-1:0]  vertex_index;
	modport source (output valid, vertex_index, input ready);
	modport sink (input valid, vertex_index, output ready);
endinterface

interface cfvg_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [cfvg_pkg::COORD_W-1:0] x_coord;
	logic signed [cfvg_pkg::COORD_W-1:0] y_coord;
	logic                                last_vertex;
	logic                                index_error;
	modport source (output valid, x_coord, y_coord, last_vertex, index_error, input ready);
	modport sink (input valid, x_coord, y_coord, last_vertex, index_error, output ready);
endinterface
`default_nettype wire

// ===== sv/cfvg_div.sv =====
// pipelined restoring divider, one phase bit per stage
`default_nettype none
module cfvg_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire cfvg_pkg::tag_t                tag_i,
	input  wire logic [cfvg_pkg::PTS_W-1:0]    rem_i,
	input  wire logic [cfvg_pkg::PTS_W-1:0]    n,
	output cfvg_pkg::tag_t                     tag_o,
	output logic [cfvg_pkg::PHASE_BITS-1:0]    q_o
);
	import cfvg_pkg::*;

	tag_t                  tag_s [PHASE_BITS];
	logic [PTS_W-1:0]      rem_s [PHASE_BITS];
	logic [PHASE_BITS-1:0] q_s   [PHASE_BITS];

	for (genvar i = 0; i < PHASE_BITS; i++) begin : g_stage
		tag_t                  tag_p;
		logic [PTS_W-1:0]      rem_p;
		logic [PHASE_BITS-1:0] q_p;
		logic [PTS_W:0]        dbl;
		logic                  ge;

		if (i == 0) begin : g_first
			assign tag_p = tag_i;
			assign rem_p = rem_i;
			assign q_p   = '0;
		end else begin : g_next
			assign tag_p = tag_s[i-1];
			assign rem_p = rem_s[i-1];
			assign q_p   = q_s[i-1];
		end

		assign dbl = {rem_p, 1'b0};
		assign ge  = dbl >= {1'b0, n};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i] <= '0;
			end else if (en) begin
				tag_s[i] <= tag_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? PTS_W'(dbl - {1'b0, n}) : dbl[PTS_W-1:0];
				q_s[i]   <= {q_p[PHASE_BITS-2:0], ge};
			end
		end
	end

	assign tag_o = tag_s[PHASE_BITS-1];
	assign q_o   = q_s[PHASE_BITS-1];

endmodule
`default_nettype wire

// ===== sv/cfvg_cordic.sv =====
// gain multiply and pipelined cordic rotation, one step per stage
`default_nettype none
module cfvg_cordic (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire cfvg_pkg::tag_t                    tag_i,
	input  wire logic [cfvg_pkg::PHASE_BITS-1:0]   phase_i,
	input  wire logic [cfvg_pkg::RAD_W-1:0]        radius,
	output cfvg_pkg::tag_t                         tag_o,
	output logic [1:0]                             quad_o,
	output logic signed [cfvg_pkg::XW-1:0]         x_o,
	output logic signed [cfvg_pkg::XW-1:0]         y_o
);
	import cfvg_pkg::*;

	logic [PROD_W-1:0]     prod;
	tag_t                  tag_s1;
	logic [1:0]            quad_s1;
	logic signed [XW-1:0]  x_s1;
	logic signed [ZW-1:0]  z_s1;

	tag_t                  tag_s [CORDIC_STEPS];
	logic [1:0]            quad_s [CORDIC_STEPS];
	logic signed [XW-1:0]  x_s [CORDIC_STEPS];
	logic signed [XW-1:0]  y_s [CORDIC_STEPS];
	logic signed [ZW-1:0]  z_s [CORDIC_STEPS];

	assign prod = PROD_W'(radius) * PROD_W'(CORDIC_GAIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1 <= tag_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1 <= phase_i[PHASE_BITS-1 -: 2];
			x_s1    <= XW'(prod[PROD_W-1:14]);
			z_s1    <= ZW'({phase_i[PHASE_BITS-3:0], {(32-PHASE_BITS){1'b0}}});
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		tag_t                 tag_p;
		logic [1:0]           quad_p;
		logic signed [XW-1:0] x_p;
		logic signed [XW-1:0] y_p;
		logic signed [ZW-1:0] z_p;
		logic signed [ZW-1:0] t;

		if (i == 0) begin : g_first
			assign tag_p  = tag_s1;
			assign quad_p = quad_s1;
			assign x_p    = x_s1;
			assign y_p    = '0;
			assign z_p    = z_s1;
		end else begin : g_next
			assign tag_p  = tag_s[i-1];
			assign quad_p = quad_s[i-1];
			assign x_p    = x_s[i-1];
			assign y_p    = y_s[i-1];
			assign z_p    = z_s[i-1];
		end

		assign t = atan_turn(5'(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i] <= '0;
			end else if (en) begin
				tag_s[i] <= tag_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quad_s[i] <= quad_p;
				if (!z_p[ZW-1]) begin
					x_s[i] <= x_p - (y_p >>> i);
					y_s[i] <= y_p + (x_p >>> i);
					z_s[i] <= z_p - t;
				end else begin
					x_s[i] <= x_p + (y_p >>> i);
					y_s[i] <= y_p - (x_p >>> i);
					z_s[i] <= z_p + t;
				end
			end
		end
	end

	assign tag_o  = tag_s[CORDIC_STEPS-1];
	assign quad_o = quad_s[CORDIC_STEPS-1];
	assign x_o    = x_s[CORDIC_STEPS-1];
	assign y_o    = y_s[CORDIC_STEPS-1];

endmodule
`default_nettype wire

// ===== sv/circle_fan_vertex_generator.sv =====
// top level of the circle fan vertex generator
// Usage:
//   vtx_in carries one word per vertex wanted (vertex_index); vtx_out returns
//   one word per input with x_coord, y_coord (signed Q12.4), last_vertex and
//   index_error. Index 0 is the centre, 1..N the rim, N+1 the closing copy.
//   Configuration: cfg_we with cfg_idx 0 writes radius, 1 writes point_count from
//   cfg_wdata[10:0] (below 3 dropped, above 1024 clamp). Write only while idle.
// Timing:
//   the pipe has one input stage, 16 divider stages (one phase bit each), one
//   gain multiply, 24 cordic steps, a quadrant stage and the rounding output
//   register. Throughput is one word per cycle while vtx_out is not stalled.
// Reset:
//   arst_n clears all valid bits and loads radius 100.0 and 50 rim points.
// Backpressure:
//   when the output word is held and vtx_out.ready is low, the whole pipe
//   freezes and vtx_in.ready drops; nothing is lost or repeated.
`default_nettype none
module circle_fan_vertex_generator (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [cfvg_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire logic [cfvg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	cfvg_in_if.sink                                  vtx_in,
	cfvg_out_if.source                               vtx_out
);
	import cfvg_pkg::*;

	logic [RAD_W-1:0]  radius_q;
	logic [PTS_W-1:0]  points_q;
	logic [PTS_W-1:0]  cfg_pts;
	logic              en;

	tag_t              tag_s1;
	logic [PTS_W-1:0]  rem_s1;
	tag_t              tag_c;
	logic [PTS_W-1:0]  k;

	tag_t                   div_tag;
	logic [PHASE_BITS-1:0]  div_q;
	tag_t                   cor_tag;
	logic [1:0]             cor_quad;
	logic signed [XW-1:0]   cor_x;
	logic signed [XW-1:0]   cor_y;

	tag_t                   tag_s2;
	logic signed [XW-1:0]   x_s2;
	logic signed [XW-1:0]   y_s2;
	tag_t                   tag_s3;
	logic signed [COORD_W-1:0] x_s3;
	logic signed [COORD_W-1:0] y_s3;

	function automatic logic signed [COORD_W-1:0] to_q4(input logic signed [XW-1:0] v);
		logic signed [XW:0]   s;
		logic signed [XW-16:0] r;
		s = (XW+1)'(v) + (XW+1)'(32768);
		r = (XW-15)'(s >>> 16);
		if (r > (XW-15)'(COORD_MAX)) begin
			return COORD_MAX;
		end else if (r < (XW-15)'(COORD_MIN)) begin
			return COORD_MIN;
		end
		return COORD_W'(r);
	endfunction

	assign en           = !tag_s3.vld || vtx_out.ready;
	assign vtx_in.ready = en;

	// configuration
	assign cfg_pts = cfg_wdata[PTS_W-1:0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			points_q <= POINTS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_RADIUS: radius_q <= cfg_wdata[RAD_W-1:0];
				REG_POINTS: begin
					if (cfg_pts >= POINTS_MIN) begin
						points_q <= (cfg_pts > POINTS_MAX) ? POINTS_MAX : cfg_pts;
					end
				end
				default: ;
			endcase
		end
	end

	// classify the index
	assign k = vtx_in.vertex_index;
	always_comb begin
		tag_c.vld = vtx_in.valid;
		if (k == '0) begin
			tag_c.kind = VK_CENTRE;
		end else if (k <= points_q) begin
			tag_c.kind = VK_RIM;
		end else if (k == points_q + 1'b1) begin
			tag_c.kind = VK_LAST;
		end else begin
			tag_c.kind = VK_ERROR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1 <= tag_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= (tag_c.kind == VK_RIM) ? k - 1'b1 : '0;
		end
	end

	cfvg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tag_i  (tag_s1),
		.rem_i  (rem_s1),
		.n      (points_q),
		.tag_o  (div_tag),
		.q_o    (div_q)
	);

	cfvg_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag_i   (div_tag),
		.phase_i (div_q),
		.radius  (radius_q),
		.tag_o   (cor_tag),
		.quad_o  (cor_quad),
		.x_o     (cor_x),
		.y_o     (cor_y)
	);

	// quadrant turn
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (en) begin
			tag_s2 <= cor_tag;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (cor_quad)
				2'd1: begin
					x_s2 <= -cor_y;
					y_s2 <= cor_x;
				end
				2'd2: begin
					x_s2 <= -cor_x;
					y_s2 <= -cor_y;
				end
				2'd3: begin
					x_s2 <= cor_y;
					y_s2 <= -cor_x;
				end
				default: begin
					x_s2 <= cor_x;
					y_s2 <= cor_y;
				end
			endcase
		end
	end

	// rounding and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else if (en) begin
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (tag_s2.kind == VK_RIM || tag_s2.kind == VK_LAST) begin
				x_s3 <= to_q4(x_s2);
				y_s3 <= to_q4(y_s2);
			end else begin
				x_s3 <= '0;
				y_s3 <= '0;
			end
		end
	end

	assign vtx_out.valid       = tag_s3.vld;
	assign vtx_out.x_coord     = x_s3;
	assign vtx_out.y_coord     = y_s3;
	assign vtx_out.last_vertex = tag_s3.kind == VK_LAST;
	assign vtx_out.index_error = tag_s3.kind == VK_ERROR;

`ifndef ASSERT_OFF
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_out.valid && vtx_out.index_error |-> x_s3 == '0 && y_s3 == '0)
		else $error("error word with nonzero coordinates");

	a_points_range: assert property (@(posedge clk) disable iff (!arst_n)
		points_q >= POINTS_MIN && points_q <= POINTS_MAX)
		else $error("point count out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_out.valid && !vtx_out.ready |=> vtx_out.valid && $stable(x_s3) && $stable(y_s3))
		else $error("stalled output word changed");

	a_in_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_out.valid && !vtx_out.ready |-> !vtx_in.ready)
		else $error("input taken while pipe frozen");
`endif

endmodule
`default_nettype wire
